### rtl/core/obdp_pkg.sv
package obdp_pkg;

	// Kinds of queued item passed from the front to the back
	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_RESP_ERROR = 2'd1;
	localparam logic [1:0] STATUS_PARSE_FAIL = 2'd2;
	localparam logic [1:0] STATUS_POLL_FAIL  = 2'd3;

	// Characters of interest
	localparam logic [7:0] CHAR_NUL      = 8'h00;
	localparam logic [7:0] CHAR_TAB      = 8'h09;
	localparam logic [7:0] CHAR_LF       = 8'h0A;
	localparam logic [7:0] CHAR_CR       = 8'h0D;
	localparam logic [7:0] CHAR_SPACE    = 8'h20;
	localparam logic [7:0] CHAR_COLON    = 8'h3A;
	localparam logic [7:0] CHAR_PROMPT   = 8'h3E;
	localparam logic [7:0] CHAR_QUESTION = 8'h3F;
	localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFFSET   = 8'h20;

	// Schedule
	localparam int unsigned SLOT_COUNT = 5;
	localparam logic [2:0] SLOT_RPM      = 3'd0;
	localparam logic [2:0] SLOT_SPEED    = 3'd1;
	localparam logic [2:0] SLOT_COOLANT  = 3'd2;
	localparam logic [2:0] SLOT_THROTTLE = 3'd3;
	localparam logic [2:0] SLOT_FUEL     = 3'd4;
	localparam logic [2:0] SLOT_LAST     = 3'(SLOT_COUNT - 1);

	localparam logic [7:0] PID_RPM      = 8'h0C;
	localparam logic [7:0] PID_SPEED    = 8'h0D;
	localparam logic [7:0] PID_COOLANT  = 8'h05;
	localparam logic [7:0] PID_THROTTLE = 8'h11;
	localparam logic [7:0] PID_FUEL     = 8'h2F;

	localparam logic [2:0] PREFIX_LEN  = 3'd4;
	localparam logic [2:0] DIGITS_BAD  = 3'd7;
	localparam logic [2:0] DIGITS_WIDE = 3'd4;
	localparam logic [2:0] DIGITS_BYTE = 3'd2;

	// Failure words, right aligned in a common width
	localparam int unsigned WORD_CHARS = 15;
	localparam int unsigned WORD_BITS  = 8 * WORD_CHARS;
	localparam logic [WORD_BITS-1:0] WORD_NODATA = "NODATA";
	localparam logic [WORD_BITS-1:0] WORD_ERROR  = "ERROR";
	localparam logic [WORD_BITS-1:0] WORD_UNABLE = "UNABLETOCONNECT";
	localparam logic [3:0] LEN_NODATA = 4'd6;
	localparam logic [3:0] LEN_ERROR  = 4'd5;
	localparam logic [3:0] LEN_UNABLE = 4'd15;

	localparam logic [8:0] COOLANT_OFFSET = 9'd40;
	localparam logic [7:0] PCT_SCALE      = 8'd100;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
	} obdp_item_t;

	// Character p of a right-aligned word of length len
	function automatic logic [7:0] word_char(input logic [WORD_BITS-1:0] word,
			input logic [3:0] len, input logic [3:0] p);
		logic [6:0] base;
		begin
			base = 7'({3'd0, len - 4'd1 - p} << 3);
			word_char = (p < len) ? word[base +: 8] : CHAR_NUL;
		end
	endfunction

	// Streaming match step; every word here has a first character that
	// never recurs, so a mismatch falls back to one or zero.
	function automatic logic [3:0] word_step(input logic [3:0] p, input logic [7:0] ch,
			input logic [7:0] want, input logic [7:0] first);
		begin
			if (ch == want)
				word_step = p + 4'd1;
			else if (ch == first)
				word_step = 4'd1;
			else
				word_step = 4'd0;
		end
	endfunction

	function automatic logic [7:0] slot_pid(input logic [2:0] slot);
		begin
			case (slot)
				SLOT_RPM:      slot_pid = PID_RPM;
				SLOT_SPEED:    slot_pid = PID_SPEED;
				SLOT_COOLANT:  slot_pid = PID_COOLANT;
				SLOT_THROTTLE: slot_pid = PID_THROTTLE;
				default:       slot_pid = PID_FUEL;
			endcase
		end
	endfunction

	// Character p of the "41"+PID prefix, as upper-case hex
	function automatic logic [7:0] prefix_char(input logic [2:0] slot, input logic [2:0] p);
		logic [31:0] word;
		begin
			case (slot)
				SLOT_RPM:      word = "410C";
				SLOT_SPEED:    word = "410D";
				SLOT_COOLANT:  word = "4105";
				SLOT_THROTTLE: word = "4111";
				default:       word = "412F";
			endcase
			case (p)
				3'd0:    prefix_char = word[31:24];
				3'd1:    prefix_char = word[23:16];
				3'd2:    prefix_char = word[15:8];
				3'd3:    prefix_char = word[7:0];
				default: prefix_char = CHAR_NUL;
			endcase
		end
	endfunction

	function automatic logic [2:0] slot_digits(input logic [2:0] slot);
		begin
			slot_digits = (slot == SLOT_RPM) ? DIGITS_WIDE : DIGITS_BYTE;
		end
	endfunction

	// Hex digit value; bit 4 flags a valid digit
	function automatic logic [4:0] hex_digit(input logic [7:0] ch);
		begin
			if (ch >= "0" && ch <= "9")
				hex_digit = {1'b1, 4'(ch - 8'h30)};
			else if (ch >= "A" && ch <= "F")
				hex_digit = {1'b1, 4'(ch - 8'h37)};
			else
				hex_digit = 5'd0;
		end
	endfunction

	// a*100/255 truncated: reciprocal form (x + (x>>8) + 1) >> 8, exact for x < 2^16 - 1
	function automatic logic [6:0] pct_of_byte(input logic [7:0] a);
		logic [14:0] x;
		logic [15:0] t;
		begin
			x = 15'(a) * 15'(PCT_SCALE);
			t = 16'(x) + 16'(x >> 8) + 16'd1;
			pct_of_byte = 7'(t >> 8);
		end
	endfunction

endpackage

### rtl/core/obd_pid_response_parser.sv
// OBD-II PID reply parser. Feed the adapter's ASCII reply one byte per item
// (cmd 0) and close it with the '>' prompt byte; each close gives one result
// for the PID currently due in the round-robin schedule (rpm, speed, coolant,
// throttle, fuel), then moves the schedule on. An abort item (cmd 1) stands
// for a timed-out poll: it reports poll fail, drops the link flag and keeps
// the schedule where it is. Every result carries the whole held sample, so
// the consumer may publish it when has_update is set. Only the first
// RESPONSE_BUFFER_BYTES-1 bytes of a reply are examined, and a NUL byte ends
// the text early. Rate: one byte per clock while in_stall is low, also from
// a closing byte into the next reply. out_valid is registered and rises as
// the back pops the closing item. The four-entry queue from the byte classifier
// to the matcher absorbs short stalls on the result side, then in_stall rises.
module obd_pid_response_parser import obdp_pkg::*; #(
	parameter int unsigned RESPONSE_BUFFER_BYTES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic [7:0]        data_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [7:0]        pid_code,
	output logic              has_update,
	output logic              link_up,
	output logic [13:0]       engine_rpm,
	output logic [7:0]        vehicle_speed,
	output logic signed [8:0] coolant_celsius,
	output logic [6:0]        throttle_pct,
	output logic [6:0]        fuel_level_pct
);

	logic       q_full, q_not_empty, q_push, q_pop;
	obdp_item_t q_push_item, q_head;

	// Hold off the sender only while the queue is full
	assign in_stall = q_full;

	// Front: count text bytes, drop separators, uppercase, flag closes/aborts
	obdp_front #(
		.RESPONSE_BUFFER_BYTES(RESPONSE_BUFFER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.data_byte (data_byte),
		.full      (q_full),
		.push      (q_push),
		.push_item (q_push_item)
	);

	// Queue of classified items between the two halves
	obdp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Back: word and prefix matchers, digit capture, held sample, result register
	obdp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.not_empty       (q_not_empty),
		.head            (q_head),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.pid_code        (pid_code),
		.has_update      (has_update),
		.link_up         (link_up),
		.engine_rpm      (engine_rpm),
		.vehicle_speed   (vehicle_speed),
		.coolant_celsius (coolant_celsius),
		.throttle_pct    (throttle_pct),
		.fuel_level_pct  (fuel_level_pct)
	);

	// An update is flagged exactly for ok and poll-fail results
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (has_update == (status == STATUS_OK || status == STATUS_POLL_FAIL)))
		else $error("has_update disagrees with status");

	// A poll fail always reports the link as down; any other non-error result as up
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_POLL_FAIL) |-> !link_up)
		else $error("link flag set on poll fail");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_OK || status == STATUS_PARSE_FAIL) |-> link_up)
		else $error("link flag clear on completed reply");

	// Results only ever name a scheduled PID
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pid_code == PID_RPM || pid_code == PID_SPEED ||
			pid_code == PID_COOLANT || pid_code == PID_THROTTLE || pid_code == PID_FUEL))
		else $error("unscheduled PID in result");

	// Percentages and coolant stay within their physical ranges
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (throttle_pct <= 7'd100 && fuel_level_pct <= 7'd100 &&
			coolant_celsius >= -9'sd40))
		else $error("sample out of range");

endmodule

### rtl/core/obdp_front.sv
module obdp_front import obdp_pkg::*; #(
	parameter int unsigned RESPONSE_BUFFER_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       cmd,
	input  logic [7:0] data_byte,
	input  logic       full,
	output logic       push,
	output obdp_item_t push_item
);

	localparam int unsigned CW = $clog2(RESPONSE_BUFFER_BYTES);
	localparam logic [CW-1:0] TEXT_LIMIT = CW'(RESPONSE_BUFFER_BYTES - 1);

	logic [CW-1:0] count_q, count_d;
	logic          ended_q, ended_d;
	logic          accept;

	assign accept = in_valid && !full;

	always_comb begin
		count_d        = count_q;
		ended_d        = ended_q;
		push           = 1'b0;
		push_item.kind = KIND_CHAR;
		push_item.ch   = data_byte;
		if (accept) begin
			if (cmd) begin
				push           = 1'b1;
				push_item.kind = KIND_ABORT;
				count_d        = '0;
				ended_d        = 1'b0;
			end else if (data_byte == CHAR_PROMPT) begin
				push           = 1'b1;
				push_item.kind = KIND_CLOSE;
				count_d        = '0;
				ended_d        = 1'b0;
			end else if (!ended_q && count_q < TEXT_LIMIT) begin
				count_d = count_q + 1'b1;
				if (data_byte == CHAR_NUL) begin
					ended_d = 1'b1;
				end else if (!(data_byte inside {CHAR_CR, CHAR_LF, CHAR_SPACE,
						CHAR_TAB, CHAR_COLON})) begin
					push = 1'b1;
					if (data_byte inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})
						push_item.ch = data_byte - CASE_OFFSET;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ended_q <= 1'b0;
		end else begin
			count_q <= count_d;
			ended_q <= ended_d;
		end
	end

endmodule

### rtl/core/obdp_fifo.sv
module obdp_fifo import obdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  obdp_item_t push_item,
	input  logic       pop,
	output logic       full,
	output logic       not_empty,
	output obdp_item_t head
);

	obdp_item_t          mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/obdp_back.sv
module obdp_back import obdp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              not_empty,
	input  obdp_item_t        head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [7:0]        pid_code,
	output logic              has_update,
	output logic              link_up,
	output logic [13:0]       engine_rpm,
	output logic [7:0]        vehicle_speed,
	output logic signed [8:0] coolant_celsius,
	output logic [6:0]        throttle_pct,
	output logic [6:0]        fuel_level_pct
);

	logic [2:0]  slot_q, slot_d;
	logic [2:0]  prefix_q, prefix_d;
	logic [15:0] digits_buf_q, digits_buf_d;
	logic [2:0]  taken_q, taken_d;
	logic [2:0]  nodata_q, nodata_d;
	logic [2:0]  error_q, error_d;
	logic [3:0]  unable_q, unable_d;
	logic        fail_q, fail_d;
	logic [13:0] rpm_q, rpm_d;
	logic [7:0]  speed_q, speed_d;
	logic [8:0]  coolant_q, coolant_d;
	logic [6:0]  throttle_q, throttle_d;
	logic [6:0]  fuel_q, fuel_d;
	logic        link_q, link_d;
	logic        out_valid_q;
	logic        res_fire, res_upd;
	logic [1:0]  res_status;
	logic [7:0]  ch, abyte;
	logic [4:0]  hex;
	logic [2:0]  need;

	// Take from the queue only when the output slot can hold a result
	assign pop       = not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign ch        = head.ch;
	assign hex       = hex_digit(ch);
	assign need      = slot_digits(slot_q);
	assign abyte     = (slot_q == SLOT_RPM) ? digits_buf_q[15:8] : digits_buf_q[7:0];

	always_comb begin
		slot_d       = slot_q;
		prefix_d     = prefix_q;
		digits_buf_d = digits_buf_q;
		taken_d      = taken_q;
		nodata_d     = nodata_q;
		error_d      = error_q;
		unable_d     = unable_q;
		fail_d       = fail_q;
		rpm_d        = rpm_q;
		speed_d      = speed_q;
		coolant_d    = coolant_q;
		throttle_d   = throttle_q;
		fuel_d       = fuel_q;
		link_d       = link_q;
		res_fire     = 1'b0;
		res_upd      = 1'b0;
		res_status   = STATUS_OK;
		if (pop) begin
			case (head.kind)
				KIND_CHAR: begin
					if (ch == CHAR_QUESTION)
						fail_d = 1'b1;
					nodata_d = 3'(word_step(4'(nodata_q), ch,
						word_char(WORD_NODATA, LEN_NODATA, 4'(nodata_q)),
						word_char(WORD_NODATA, LEN_NODATA, 4'd0)));
					error_d = 3'(word_step(4'(error_q), ch,
						word_char(WORD_ERROR, LEN_ERROR, 4'(error_q)),
						word_char(WORD_ERROR, LEN_ERROR, 4'd0)));
					unable_d = word_step(unable_q, ch,
						word_char(WORD_UNABLE, LEN_UNABLE, unable_q),
						word_char(WORD_UNABLE, LEN_UNABLE, 4'd0));
					if (4'(nodata_d) == LEN_NODATA || 4'(error_d) == LEN_ERROR ||
							unable_d == LEN_UNABLE) begin
						fail_d   = 1'b1;
						nodata_d = '0;
						error_d  = '0;
						unable_d = '0;
					end
					if (prefix_q < PREFIX_LEN) begin
						prefix_d = 3'(word_step(4'(prefix_q), ch,
							prefix_char(slot_q, prefix_q), prefix_char(slot_q, 3'd0)));
						if (prefix_d == PREFIX_LEN) begin
							taken_d      = '0;
							digits_buf_d = '0;
						end
					end else if (taken_q < need) begin
						if (!hex[4]) begin
							taken_d = DIGITS_BAD;
						end else begin
							digits_buf_d = {digits_buf_q[11:0], hex[3:0]};
							taken_d      = taken_q + 3'd1;
						end
					end
				end
				KIND_CLOSE: begin
					res_fire = 1'b1;
					slot_d   = (slot_q == SLOT_LAST) ? 3'd0 : slot_q + 3'd1;
					if (fail_q) begin
						res_status = STATUS_RESP_ERROR;
					end else begin
						link_d = 1'b1;
						if (prefix_q == PREFIX_LEN && taken_q == need) begin
							res_status = STATUS_OK;
							res_upd    = 1'b1;
							case (slot_q)
								SLOT_RPM:      rpm_d      = digits_buf_q[15:2];
								SLOT_SPEED:    speed_d    = abyte;
								SLOT_COOLANT:  coolant_d  = {1'b0, abyte} - COOLANT_OFFSET;
								SLOT_THROTTLE: throttle_d = pct_of_byte(abyte);
								default:       fuel_d     = pct_of_byte(abyte);
							endcase
						end else begin
							res_status = STATUS_PARSE_FAIL;
						end
					end
				end
				default: begin
					res_fire   = 1'b1;
					res_upd    = 1'b1;
					res_status = STATUS_POLL_FAIL;
					link_d     = 1'b0;
				end
			endcase
			if (res_fire) begin
				prefix_d     = '0;
				digits_buf_d = '0;
				taken_d      = '0;
				nodata_d     = '0;
				error_d      = '0;
				unable_d     = '0;
				fail_d       = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= '0;
			prefix_q     <= '0;
			digits_buf_q <= '0;
			taken_q      <= '0;
			nodata_q     <= '0;
			error_q      <= '0;
			unable_q     <= '0;
			fail_q       <= 1'b0;
			rpm_q        <= '0;
			speed_q      <= '0;
			coolant_q    <= '0;
			throttle_q   <= '0;
			fuel_q       <= '0;
			link_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			slot_q       <= slot_d;
			prefix_q     <= prefix_d;
			digits_buf_q <= digits_buf_d;
			taken_q      <= taken_d;
			nodata_q     <= nodata_d;
			error_q      <= error_d;
			unable_q     <= unable_d;
			fail_q       <= fail_d;
			rpm_q        <= rpm_d;
			speed_q      <= speed_d;
			coolant_q    <= coolant_d;
			throttle_q   <= throttle_d;
			fuel_q       <= fuel_d;
			link_q       <= link_d;
			if (res_fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Result register: a snapshot of the sample as it stands after the item
	always_ff @(posedge clk) begin
		if (res_fire) begin
			status          <= res_status;
			pid_code        <= slot_pid(slot_q);
			has_update      <= res_upd;
			link_up         <= link_d;
			engine_rpm      <= rpm_d;
			vehicle_speed   <= speed_d;
			coolant_celsius <= coolant_d;
			throttle_pct    <= throttle_d;
			fuel_level_pct  <= fuel_d;
		end
	end

endmodule
